// ===== hdl/reserved_fifo_slot_allocator_core_macros.svh =====
// Assertion macros used by the slot allocator core.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef RESERVED_FIFO_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define RESERVED_FIFO_SLOT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define RFSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define RFSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");
`else
`define RFSA_ASSERT_IMP(lbl, ante, cons)
`define RFSA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/rfsa_pkg.sv =====
// Shared constants, codes and types of the slot allocator.
package rfsa_pkg;

    localparam int NUM_SLOTS_DEF    = 64;
    localparam int RESERVE_FREE_DEF = 5;
    localparam int SIZE_RESET       = 64;

    localparam int CFG_W       = 7;
    localparam int SLOT_IDX_W  = 6;
    localparam int STATUS_W    = 2;
    localparam int BUSY_W      = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_EXHAUSTED    = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic [BUSY_W-1:0]     busy_count;
        status_t               status;
        logic [SLOT_IDX_W-1:0] granted_index;
    } result_t;

endpackage

// ===== hdl/reserved_fifo_slot_allocator_core.sv =====
// Top level of the slot allocator: free-slot queue, free bitmap and request decision.
//
//   Channel   | Signals                     | Content
//   ----------+-----------------------------+------------------------------------------
//   config    | cfg_we, cfg_wdata[6:0]      | slots_in_use (pool size), refills queue
//   request   | s_tvalid/s_tready/s_tdata   | tdata[5:0] slot_index, tuser[0] kind
//   result    | m_tvalid/m_tready/m_tdata   | [5:0] granted_index, [7:6] status,
//             |                             | [14:8] busy_count
//
// One request transfer can be taken every cycle while the result register is not stalled.
// A request is held in the input register, where the free queue and the free bitmap are
// read from their RAMs, and its result is then held in the result register.
// Reset and every write of slots_in_use refill the pool at once: per-entry valid bits
// mark RAM entries written since the refill, and an entry that is not valid reads as its
// refill value, so there is no clearing pass. A stalled result register holds the input
// register, which then refuses new requests until the result transfer completes.
`include "reserved_fifo_slot_allocator_core_macros.svh"

module reserved_fifo_slot_allocator_core #(
    parameter int NUM_SLOTS    = rfsa_pkg::NUM_SLOTS_DEF,
    parameter int RESERVE_FREE = rfsa_pkg::RESERVE_FREE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rfsa_pkg::CFG_W-1:0]     cfg_wdata,  // slots_in_use
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rfsa_pkg::S_TDATA_W-1:0] s_tdata,    // [5:0] slot_index, [7:6] zero
    input  logic                           s_tuser,    // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rfsa_pkg::M_TDATA_W-1:0] m_tdata     // [5:0] granted_index,
                                                       // [7:6] status, [14:8] busy_count,
                                                       // [15] zero
);
    import rfsa_pkg::*;

    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int RST_POOL  = (SIZE_RESET > NUM_SLOTS) ? NUM_SLOTS : SIZE_RESET;
    localparam int RST_TAIL  = (RST_POOL == NUM_SLOTS) ? 0 : RST_POOL;
    localparam int LAST_SLOT = NUM_SLOTS - 1;

    // Pool bookkeeping.
    logic [CNT_W-1:0]  pool_reg;
    logic [CNT_W-1:0]  free_total_reg, free_total_next;
    logic [CNT_W-1:0]  alloc_reg, alloc_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [NUM_SLOTS-1:0] q_valid_reg;
    logic [NUM_SLOTS-1:0] m_valid_reg;

    // Input register and the read-side context captured with it.
    logic                  s1_valid_reg;
    logic                  s1_kind_reg;
    logic [SLOT_IDX_W-1:0] s1_slot_reg;
    logic [SLOT_W-1:0]     q_addr_reg;
    logic [SLOT_W-1:0]     m_addr_reg;
    logic                  q_fwd_reg;
    logic [SLOT_W-1:0]     q_fwd_data_reg;
    logic                  m_fwd_reg;
    logic                  m_fwd_data_reg;

    logic              s1_adv;
    logic              s1_fire;
    logic              in_fire;
    logic [SLOT_W-1:0] s1_slot_addr;
    logic [SLOT_W-1:0] q_rdata;
    logic [0:0]        m_rdata;
    logic [SLOT_W-1:0] q_word;
    logic              m_bit;
    logic              alloc_ok;
    logic              slot_out_of_range;
    logic              q_we;
    logic              m_we;
    logic [SLOT_W-1:0] m_waddr;
    logic              m_wdata;
    logic [SLOT_W-1:0] m_raddr;
    logic [CNT_W-1:0]  cfg_pool;
    result_t           res;

    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_fire  = s_tvalid && s_tready;

    assign s1_slot_addr = SLOT_W'(s1_slot_reg);
    assign m_raddr      = SLOT_W'(s_tdata[SLOT_IDX_W-1:0]);

    // Pool size saturates at the capacity of the storage.
    assign cfg_pool = (32'(cfg_wdata) > NUM_SLOTS) ? CNT_W'(NUM_SLOTS) : CNT_W'(cfg_wdata);

    // Read data for the request in the input register: a write by the previous request
    // at the same address takes precedence, then RAM data if written since the refill,
    // otherwise the refill value.
    always_comb
    begin
        if (q_fwd_reg)
        begin
            q_word = q_fwd_data_reg;
        end
        else if (q_valid_reg[q_addr_reg])
        begin
            q_word = q_rdata;
        end
        else
        begin
            q_word = q_addr_reg;
        end

        if (m_fwd_reg)
        begin
            m_bit = m_fwd_data_reg;
        end
        else if (m_valid_reg[m_addr_reg])
        begin
            m_bit = m_rdata[0];
        end
        else
        begin
            m_bit = CNT_W'(m_addr_reg) < pool_reg;
        end
    end

    assign alloc_ok          = 32'(free_total_reg) > RESERVE_FREE;
    assign slot_out_of_range = 32'(s1_slot_reg) >= 32'(pool_reg);

    // Request decision and the state it leaves behind.
    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        free_total_next   = free_total_reg;
        alloc_next        = alloc_reg;
        q_we              = 1'b0;
        m_we              = 1'b0;
        m_waddr           = q_word;
        m_wdata           = 1'b0;
        res.granted_index = '0;
        res.status        = ST_OK;

        if (s1_fire)
        begin
            if (s1_kind_reg == KIND_ALLOC)
            begin
                if (!alloc_ok)
                begin
                    res.status = ST_EXHAUSTED;
                end
                else
                begin
                    res.granted_index = SLOT_IDX_W'(q_word);
                    m_we              = 1'b1;
                    m_waddr           = q_word;
                    m_wdata           = 1'b0;
                    head_next         = (head_reg == SLOT_W'(LAST_SLOT)) ? '0
                                                                          : head_reg + 1'b1;
                    free_total_next   = free_total_reg - 1'b1;
                    alloc_next        = alloc_reg + 1'b1;
                end
            end
            else
            begin
                if (slot_out_of_range)
                begin
                    res.status = ST_RANGE;
                end
                else if (m_bit)
                begin
                    res.status = ST_ALREADY_FREE;
                end
                else
                begin
                    m_we            = 1'b1;
                    m_waddr         = s1_slot_addr;
                    m_wdata         = 1'b1;
                    q_we            = 1'b1;
                    tail_next       = (tail_reg == SLOT_W'(LAST_SLOT)) ? '0
                                                                        : tail_reg + 1'b1;
                    free_total_next = free_total_reg + 1'b1;
                    if (alloc_reg != '0)
                    begin
                        alloc_next = alloc_reg - 1'b1;
                    end
                end
            end
        end

        res.busy_count = BUSY_W'(alloc_next);
    end

    // Pool state; a size write refills the pool.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg       <= CNT_W'(RST_POOL);
            free_total_reg <= CNT_W'(RST_POOL);
            alloc_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= SLOT_W'(RST_TAIL);
            q_valid_reg    <= '0;
            m_valid_reg    <= '0;
        end
        else if (cfg_we)
        begin
            pool_reg       <= cfg_pool;
            free_total_reg <= cfg_pool;
            alloc_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= (cfg_pool == CNT_W'(NUM_SLOTS)) ? '0 : SLOT_W'(cfg_pool);
            q_valid_reg    <= '0;
            m_valid_reg    <= '0;
        end
        else
        begin
            free_total_reg <= free_total_next;
            alloc_reg      <= alloc_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            if (q_we)
            begin
                q_valid_reg[tail_reg] <= 1'b1;
            end
            if (m_we)
            begin
                m_valid_reg[m_waddr] <= 1'b1;
            end
        end
    end

    // Input register control and the forwarding flags of its RAM reads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            q_fwd_reg    <= 1'b0;
            m_fwd_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
            q_fwd_reg    <= q_we && (tail_reg == head_next);
            m_fwd_reg    <= m_we && (m_waddr == m_raddr);
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg    <= s_tuser;
            s1_slot_reg    <= s_tdata[SLOT_IDX_W-1:0];
            q_addr_reg     <= head_next;
            m_addr_reg     <= m_raddr;
            q_fwd_data_reg <= s1_slot_addr;
            m_fwd_data_reg <= m_wdata;
        end
    end

    // Free queue: pop address is the head after the request ahead of this one commits.
    rfsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SLOTS)
    ) u_free_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (s1_slot_addr),
        .re    (in_fire),
        .raddr (head_next),
        .rdata (q_rdata)
    );

    // Free bitmap, one bit per slot.
    rfsa_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SLOTS)
    ) u_free_mark (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (in_fire),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    rfsa_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_fire),
        .res      (res),
        .can_load (s1_adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Every slot of the pool is either free or allocated.
    `RFSA_ASSERT_IMP(a_pool_balance, 1'b1, ((free_total_reg + alloc_reg) == pool_reg))
    // A size write leaves no slot allocated and the queue head at the start.
    `RFSA_ASSERT_NXT(a_refill, cfg_we, (head_reg == '0) && (alloc_reg == '0))
    // A request held by a stalled result register stays in the input register.
    `RFSA_ASSERT_NXT(a_s1_hold, s1_valid_reg && !s1_adv, s1_valid_reg)

endmodule

// ===== hdl/rfsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/rfsa_out_stage.sv =====
// Result register that holds one result until the downstream side takes it.
module rfsa_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  rfsa_pkg::result_t             res,
    output logic                          can_load,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rfsa_pkg::M_TDATA_W-1:0] m_tdata
);
    import rfsa_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, res_reg};

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the reserved slot allocator: pool sizes, grants, releases and stalls.
`timescale 1ns / 1ps

module tb_top;
    import rfsa_pkg::*;

    // Clock period, reset length and the watchdog limit. The slowest correct run is
    // roughly 950 transfers, each waiting out idling on both sides, and a handful of
    // long hold-offs and drains, which stays well under the watchdog limit.
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    // Settling time after the last reply, covering any late activity.
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_PCT      = 17;
    // Ring of owed replies; far deeper than the few requests the allocator can hold.
    localparam int REPLY_SLOTS   = 64;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // [5:0] slot_index, [7:6] zero
    logic                   s_tuser;    // [0] kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // [5:0] granted_index, [7:6] status,
                                        // [14:8] busy_count, [15] zero

    reserved_fifo_slot_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow copy of the allocator. The free FIFO, the per-slot free flags and the
    // two FIFO pointers wrap exactly like the hardware, so the order in which freed
    // slots come back out is predicted as well as the counts.
    logic [SLOT_IDX_W-1:0] free_fifo [NUM_SLOTS_DEF];
    bit                    slot_is_free [NUM_SLOTS_DEF];
    logic [SLOT_IDX_W-1:0] fifo_rd_ptr;
    logic [SLOT_IDX_W-1:0] fifo_wr_ptr;
    int unsigned           pool_slots;
    int unsigned           free_slots;
    int unsigned           busy_slots;

    // Replies that the allocator still owes, oldest first. The sender only advances
    // the write count and the checker only advances the read count.
    result_t     owed_reply [REPLY_SLOTS];
    int unsigned owed_wr_count;
    int unsigned owed_rd_count;

    int unsigned error_count;
    int unsigned cycle_count;
    bit          idle_on;
    int          ready_hold_cycles;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Watchdog: a hang or a lost transfer ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("ERROR @%0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    // Number of replies still owed.
    function automatic int unsigned replies_owed();
        return owed_wr_count - owed_rd_count;
    endfunction

    // Appends one owed reply behind the others.
    function automatic void stash_reply(input result_t reply);
        owed_reply[owed_wr_count % REPLY_SLOTS] = reply;
        owed_wr_count++;
    endfunction

    // Takes the oldest owed reply.
    function automatic result_t take_reply();
        result_t reply;
        reply = owed_reply[owed_rd_count % REPLY_SLOTS];
        owed_rd_count++;
        return reply;
    endfunction

    // Restores the shadow pool the way a reset or a size write does. Sizes above the
    // slot count saturate, so 127 behaves exactly like 64.
    function automatic void refill_pool(input logic [CFG_W-1:0] size);
        pool_slots = (size > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : size;
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
        begin
            free_fifo[i]    = SLOT_IDX_W'(i);
            slot_is_free[i] = (i < pool_slots);
        end
        fifo_rd_ptr = '0;
        fifo_wr_ptr = SLOT_IDX_W'(pool_slots % NUM_SLOTS_DEF);
        free_slots  = pool_slots;
        busy_slots  = 0;
    endfunction

    // Applies one accepted request to the shadow pool and returns the reply it must
    // produce. An allocate is refused while the free count is at or below the reserve;
    // a release is refused for slots outside the pool or slots that are already free.
    function automatic result_t apply_slot_request(input logic kind,
                                                   input logic [SLOT_IDX_W-1:0] slot);
        result_t reply;
        reply.granted_index = '0;
        reply.status        = ST_OK;
        if (kind == KIND_ALLOC)
        begin
            if (free_slots <= RESERVE_FREE_DEF)
                reply.status = ST_EXHAUSTED;
            else
            begin
                reply.granted_index = free_fifo[fifo_rd_ptr];
                slot_is_free[reply.granted_index] = 1'b0;
                fifo_rd_ptr = fifo_rd_ptr + 1'b1;
                free_slots--;
                busy_slots++;
            end
        end
        else
        begin
            if (slot >= pool_slots)
                reply.status = ST_RANGE;
            else if (slot_is_free[slot])
                reply.status = ST_ALREADY_FREE;
            else
            begin
                slot_is_free[slot] = 1'b1;
                if (busy_slots > 0)
                    busy_slots--;
                free_fifo[fifo_wr_ptr] = slot;
                fifo_wr_ptr = fifo_wr_ptr + 1'b1;
                free_slots++;
            end
        end
        reply.busy_count = BUSY_W'(busy_slots);
        return reply;
    endfunction

    // Result side: m_tready changes on the falling edge. Normally it drops at random,
    // never while idling is switched off, and it stays low for a counted stretch
    // whenever a test asks for a hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (ready_hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            ready_hold_cycles--;
        end
        else if (idle_on && ($urandom_range(99) < IDLE_PCT))
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // Result checker: every result transfer is compared field by field with the oldest
    // reply still owed.
    always @(posedge clk)
    begin : check_reply
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_owed() == 0)
                report_mismatch("unexpected result transfer, tdata", m_tdata, 0);
            else
            begin
                want = take_reply();
                if (m_tdata[5:0] != want.granted_index)
                    report_mismatch("granted_index", m_tdata[5:0], want.granted_index);
                if (m_tdata[7:6] != want.status)
                    report_mismatch("status", m_tdata[7:6], want.status);
                if (m_tdata[14:8] != want.busy_count)
                    report_mismatch("busy_count", m_tdata[14:8], want.busy_count);
                if (m_tdata[15] !== 1'b0)
                    report_mismatch("tdata pad bit", m_tdata[15], 0);
            end
        end
    end

    // Offers one request and returns at the rising edge where the transfer happens.
    // Inputs move on the falling edge only; valid stays high after the transfer so a
    // back-to-back request never lowers and raises it in the same step.
    task automatic send_request(input logic kind, input logic [SLOT_IDX_W-1:0] slot);
        @(negedge clk);
        while (idle_on && ($urandom_range(99) < IDLE_PCT))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, slot};
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        stash_reply(apply_slot_request(kind, slot));
    endtask

    // Mostly well-formed traffic: allocates, and releases of slots that are really
    // held. The noise share sends any kind with any index, which brings in double
    // releases, out-of-range releases and random index bits on allocates.
    task automatic send_random_request(input int noise_pct);
        int                    pick;
        int                    held_count;
        logic [SLOT_IDX_W-1:0] held_slots [NUM_SLOTS_DEF];
        pick       = $urandom_range(99);
        held_count = 0;
        for (int i = 0; i < pool_slots; i++)
            if (!slot_is_free[i])
            begin
                held_slots[held_count] = SLOT_IDX_W'(i);
                held_count++;
            end
        if (pick < noise_pct)
            send_request(1'($urandom_range(1)), SLOT_IDX_W'($urandom_range(63)));
        else if (pick < 55 || held_count == 0)
            send_request(KIND_ALLOC, SLOT_IDX_W'($urandom_range(63)));
        else
            send_request(KIND_RELEASE, held_slots[$urandom_range(held_count - 1)]);
    endtask

    // Stops offering and waits until every owed reply has arrived, then waits out the
    // settle time. Returns at a falling edge.
    task automatic drain_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (replies_owed() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the pool size while the allocator is idle and refills the shadow pool.
    task automatic write_pool_size(input logic [CFG_W-1:0] size);
        drain_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(negedge clk);
        cfg_we    <= 1'b0;
        refill_pool(size);
    endtask

    // Every status code, the pool-size extremes, saturation of large sizes, pools
    // at or below the reserve and an empty pool, with hand-picked requests.
    task automatic test_directed_codes();
        send_request(KIND_RELEASE, 6'd0);      // already free after reset
        send_request(KIND_RELEASE, 6'd63);     // already free, top index
        send_request(KIND_ALLOC, 6'd63);       // index field ignored on allocate
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_ALLOC, 6'd42);
        send_request(KIND_RELEASE, 6'd1);
        send_request(KIND_RELEASE, 6'd1);      // double release
        write_pool_size(7'd8);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_ALLOC, 6'd0);        // only the reserve is left
        send_request(KIND_RELEASE, 6'd8);      // just outside the pool
        send_request(KIND_RELEASE, 6'd63);
        send_request(KIND_RELEASE, 6'd2);
        write_pool_size(7'd0);                 // empty pool
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_RELEASE, 6'd0);
        write_pool_size(7'd127);               // saturates to the full pool
        send_request(KIND_RELEASE, 6'd63);
        send_request(KIND_ALLOC, 6'd21);
        write_pool_size(7'd3);                 // smaller than the reserve
        send_request(KIND_ALLOC, 6'd0);
        write_pool_size(7'd6);                 // smallest usable pool
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_ALLOC, 6'd0);
    endtask

    // Full pool with idling switched off on both sides: back-to-back transfers run
    // long enough for both FIFO pointers to wrap.
    task automatic test_full_pool_streaming();
        write_pool_size(7'd64);
        idle_on = 1'b0;
        repeat (220) send_random_request(10);
        idle_on = 1'b1;
    endtask

    // The result side holds off for a long counted stretch while requests keep
    // coming, so the pipeline fills and s_tready must drop.
    task automatic test_result_hold_off();
        write_pool_size(7'd40);
        ready_hold_cycles = 80;
        repeat (30) send_random_request(15);
    endtask

    // Several pool sizes, extremes among them, each with random traffic. Halfway
    // through each size the request side pauses until every reply is back.
    task automatic test_random_pool_sizes();
        logic [CFG_W-1:0] sizes [7];
        sizes[0] = 7'd6;
        sizes[1] = 7'd64;
        sizes[2] = 7'd65;
        sizes[3] = 7'd12;
        sizes[4] = CFG_W'($urandom_range(64, 6));
        sizes[5] = CFG_W'($urandom_range(127, 65));
        sizes[6] = CFG_W'($urandom_range(5));
        foreach (sizes[k])
        begin
            write_pool_size(sizes[k]);
            repeat (50) send_random_request(20);
            drain_replies();
            repeat (50) send_random_request(20);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tuser           = KIND_ALLOC;
        m_tready          = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        owed_wr_count     = 0;
        owed_rd_count     = 0;
        idle_on           = 1'b1;
        ready_hold_cycles = 0;
        refill_pool(CFG_W'(SIZE_RESET));
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_codes();
        test_full_pool_streaming();
        test_result_hold_off();
        test_random_pool_sizes();

        drain_replies();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
